// ===== src/mck_pkg.sv =====
// Shared types, constants, character code table and microprogram for the
// Morse character keyer. Standalone; used by every module of the keyer.
package mck_pkg;

  // Symbol kinds on the result port.
  localparam logic [2:0] KIND_DOT   = 3'd0;
  localparam logic [2:0] KIND_DASH  = 3'd1;
  localparam logic [2:0] KIND_EGAP  = 3'd2;
  localparam logic [2:0] KIND_LGAP  = 3'd3;
  localparam logic [2:0] KIND_WGAP  = 3'd4;
  localparam logic [2:0] KIND_BUZZ  = 3'd5;

  localparam logic [14:0] BUZZ_FREQ = 15'd200;
  localparam logic [15:0] BUZZ_MS   = 16'd1000;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TONE_FREQUENCY = 3'd0;
  localparam logic [2:0] REG_DOT_DURATION   = 3'd1;
  localparam logic [2:0] REG_DASH_DURATION  = 3'd2;
  localparam logic [2:0] REG_ELEMENT_GAP    = 3'd3;
  localparam logic [2:0] REG_LETTER_GAP     = 3'd4;
  localparam logic [2:0] REG_WORD_GAP       = 3'd5;

  localparam logic [14:0] RST_TONE_FREQUENCY = 15'd500;
  localparam logic [15:0] RST_DOT_DURATION   = 16'd100;
  localparam logic [15:0] RST_DASH_DURATION  = 16'd300;
  localparam logic [15:0] RST_ELEMENT_GAP    = 16'd100;
  localparam logic [15:0] RST_LETTER_GAP     = 16'd900;
  localparam logic [15:0] RST_WORD_GAP       = 16'd700;

  // Character classes seen by the sequencer at dispatch.
  localparam logic [1:0] CLASS_CODED   = 2'd0;
  localparam logic [1:0] CLASS_SPACE   = 2'd1;
  localparam logic [1:0] CLASS_INVALID = 2'd2;

  // Microprogram steps.
  localparam logic [2:0] STEP_IDLE = 3'd0;
  localparam logic [2:0] STEP_ELEM = 3'd1;
  localparam logic [2:0] STEP_EGAP = 3'd2;
  localparam logic [2:0] STEP_LGAP = 3'd3;
  localparam logic [2:0] STEP_WGAP = 3'd4;
  localparam logic [2:0] STEP_BUZZ = 3'd5;

  // What a step puts on the result port.
  localparam logic [2:0] EMIT_NONE = 3'd0;
  localparam logic [2:0] EMIT_ELEM = 3'd1;
  localparam logic [2:0] EMIT_EGAP = 3'd2;
  localparam logic [2:0] EMIT_LGAP = 3'd3;
  localparam logic [2:0] EMIT_WGAP = 3'd4;
  localparam logic [2:0] EMIT_BUZZ = 3'd5;

  // Sequencing conditions.
  localparam logic [1:0] COND_ALWAYS   = 2'd0;
  localparam logic [1:0] COND_DISPATCH = 2'd1;
  localparam logic [1:0] COND_MORE     = 2'd2;

  // Code word: bits 10..8 element count, bits 5..0 pattern, first element in
  // the highest used bit, 1 meaning dash.
  localparam logic [10:0] LETTER_CODES [26] = '{
    11'h201, 11'h408, 11'h40A, 11'h304, 11'h100, 11'h402, 11'h306, 11'h400,
    11'h200, 11'h407, 11'h305, 11'h404, 11'h203, 11'h202, 11'h307, 11'h406,
    11'h40D, 11'h302, 11'h300, 11'h101, 11'h301, 11'h401, 11'h303, 11'h409,
    11'h40B, 11'h40C
  };
  localparam logic [10:0] DIGIT_CODES [10] = '{
    11'h51F, 11'h50F, 11'h507, 11'h503, 11'h501, 11'h500, 11'h510, 11'h518,
    11'h51C, 11'h51E
  };
  localparam logic [10:0] CODE_PERIOD = 11'h615;
  localparam logic [10:0] CODE_COMMA  = 11'h633;

  typedef struct packed {
    logic [14:0] tone_frequency;
    logic [15:0] dot_duration;
    logic [15:0] dash_duration;
    logic [15:0] element_gap;
    logic [15:0] letter_gap;
    logic [15:0] word_gap;
  } cfg_t;

  typedef struct packed {
    logic [1:0] char_class;
    logic [2:0] len;
    logic [5:0] pat;
  } char_info_t;

  typedef struct packed {
    logic [1:0] char_class;
    logic       more;
  } dp_status_t;

  typedef struct packed {
    logic [2:0] emit_sel;
    logic       last;
    logic       load;
    logic       shift;
    logic [1:0] cond;
    logic [2:0] target;
  } ctrl_word_t;

  // Folds case, looks up the code and left-aligns the pattern so that the
  // first element sits in bit 5.
  function automatic char_info_t char_lookup(input logic [7:0] raw);
    logic [7:0]  c;
    logic [10:0] code;
    char_info_t  info;
    c = raw;
    if (raw >= 8'h41 && raw <= 8'h5A) begin
      c = raw + 8'd32;
    end
    code = '0;
    if (c >= 8'h61 && c <= 8'h7A) begin
      code = LETTER_CODES[5'(c - 8'h61)];
    end else if (c >= 8'h30 && c <= 8'h39) begin
      code = DIGIT_CODES[4'(c - 8'h30)];
    end else if (c == 8'h2E) begin
      code = CODE_PERIOD;
    end else if (c == 8'h2C) begin
      code = CODE_COMMA;
    end
    info.len = code[10:8];
    info.pat = code[5:0] << (3'd6 - code[10:8]);
    if (c == 8'h20) begin
      info.char_class = CLASS_SPACE;
    end else if (code == '0) begin
      info.char_class = CLASS_INVALID;
    end else begin
      info.char_class = CLASS_CODED;
    end
    return info;
  endfunction

  // The microprogram: one control word per step.
  function automatic ctrl_word_t microcode(input logic [2:0] step);
    ctrl_word_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.load = 1'b1;
        w.cond = COND_DISPATCH;
      end
      STEP_ELEM: begin
        w.emit_sel = EMIT_ELEM;
        w.shift    = 1'b1;
        w.cond     = COND_MORE;
        w.target   = STEP_LGAP;
      end
      STEP_EGAP: begin
        w.emit_sel = EMIT_EGAP;
        w.cond     = COND_ALWAYS;
        w.target   = STEP_ELEM;
      end
      STEP_LGAP: begin
        w.emit_sel = EMIT_LGAP;
        w.last     = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = STEP_IDLE;
      end
      STEP_WGAP: begin
        w.emit_sel = EMIT_WGAP;
        w.last     = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = STEP_IDLE;
      end
      STEP_BUZZ: begin
        w.emit_sel = EMIT_BUZZ;
        w.last     = 1'b1;
        w.cond     = COND_ALWAYS;
        w.target   = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/morse_character_keyer.sv =====
// Top level of the Morse character keyer: configuration registers and the
// sequencer/datapath pair. Depends on mck_pkg, mck_sequencer, mck_datapath.
//
// A character byte is taken when start is high and busy is low. The keyer
// then plays out that character's run of results, one result per clock
// cycle, each marked by a one-cycle result_strobe; the receiver cannot stall
// them, so it must take every strobe as it comes. Upper case is folded to
// lower case. A letter, digit, period or comma with L elements gives 2*L
// results (each tone, an element gap between tones, and a closing letter
// gap); a space gives a single word gap and any other byte a single 200 Hz,
// 1000 ms buzz. The final result of each run has last_of_run set. Each run is
// set by the microprogram, which spends one step per result and one dispatch
// step; the period and comma are the six-element codes. Results appear in
// the cycle after their step because the result port is registered; busy
// falls as the last result is shown, so the next character can be taken in
// that same cycle. Configuration writes (cfg_we, cfg_index, cfg_data) take
// effect at once and are meant to be made only while no run is in progress;
// indexes beyond the register list are ignored, and the tone frequency keeps
// the low 15 bits of the written data.
module morse_character_keyer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [7:0]  char_code,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_strobe,
  output logic [2:0]  symbol_kind,
  output logic        tone_on,
  output logic [14:0] frequency_hz,
  output logic [15:0] duration_ms,
  output logic        last_of_run
);

  mck_pkg::cfg_t       cfg;
  mck_pkg::ctrl_word_t ctrl;
  mck_pkg::dp_status_t status;
  logic                accept;

  // A request is taken only at the dispatch step of the program.
  assign accept = start && !busy;

  // Configuration registers, written directly from the port.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tone_frequency <= mck_pkg::RST_TONE_FREQUENCY;
      cfg.dot_duration   <= mck_pkg::RST_DOT_DURATION;
      cfg.dash_duration  <= mck_pkg::RST_DASH_DURATION;
      cfg.element_gap    <= mck_pkg::RST_ELEMENT_GAP;
      cfg.letter_gap     <= mck_pkg::RST_LETTER_GAP;
      cfg.word_gap       <= mck_pkg::RST_WORD_GAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mck_pkg::REG_TONE_FREQUENCY: cfg.tone_frequency <= cfg_data[14:0];
        mck_pkg::REG_DOT_DURATION:   cfg.dot_duration   <= cfg_data;
        mck_pkg::REG_DASH_DURATION:  cfg.dash_duration  <= cfg_data;
        mck_pkg::REG_ELEMENT_GAP:    cfg.element_gap    <= cfg_data;
        mck_pkg::REG_LETTER_GAP:     cfg.letter_gap     <= cfg_data;
        mck_pkg::REG_WORD_GAP:       cfg.word_gap       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mck_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  mck_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .char_code     (char_code),
    .ctrl          (ctrl),
    .cfg           (cfg),
    .status        (status),
    .result_strobe (result_strobe),
    .symbol_kind   (symbol_kind),
    .tone_on       (tone_on),
    .frequency_hz  (frequency_hz),
    .duration_ms   (duration_ms),
    .last_of_run   (last_of_run)
  );

`ifndef SYNTHESIS
  // Every accepted request starts a run that holds the sequencer busy.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("accepted request did not start a run");

  // Results only come from steps of a run in progress.
  a_strobe_in_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result strobe without a run in progress");

  // The closing result of a run coincides with the return to the dispatch step.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_of_run) |-> !busy)
    else $error("run still busy after its last result");

  // Tone results are exactly dots, dashes and the buzz.
  a_tone_kind: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> (tone_on == (symbol_kind == mck_pkg::KIND_DOT ||
                                   symbol_kind == mck_pkg::KIND_DASH ||
                                   symbol_kind == mck_pkg::KIND_BUZZ)))
    else $error("tone flag does not match symbol kind");
`endif

endmodule

// ===== src/mck_sequencer.sv =====
// Step counter and microprogram table of the Morse keyer.
// Depends on mck_pkg for the control word layout and the program itself.
module mck_sequencer (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mck_pkg::dp_status_t status,
  output mck_pkg::ctrl_word_t ctrl,
  output logic                busy
);

  logic [2:0] pc;
  logic [2:0] pc_next;

  assign ctrl = mck_pkg::microcode(pc);
  assign busy = (pc != mck_pkg::STEP_IDLE);

  always_comb begin
    pc_next = ctrl.target;
    unique case (ctrl.cond)
      mck_pkg::COND_ALWAYS: pc_next = ctrl.target;
      mck_pkg::COND_DISPATCH: begin
        if (!start) begin
          pc_next = pc;
        end else if (status.char_class == mck_pkg::CLASS_SPACE) begin
          pc_next = mck_pkg::STEP_WGAP;
        end else if (status.char_class == mck_pkg::CLASS_INVALID) begin
          pc_next = mck_pkg::STEP_BUZZ;
        end else begin
          pc_next = mck_pkg::STEP_ELEM;
        end
      end
      // More elements to go: fall through to the element gap step.
      mck_pkg::COND_MORE: pc_next = status.more ? 3'(pc + 3'd1) : ctrl.target;
      default: pc_next = mck_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mck_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== src/mck_datapath.sv =====
// Character decode, element shift register and result register of the keyer.
// Depends on mck_pkg for the code table, control word and register types.
module mck_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          char_code,
  input  mck_pkg::ctrl_word_t ctrl,
  input  mck_pkg::cfg_t       cfg,
  output mck_pkg::dp_status_t status,
  output logic                result_strobe,
  output logic [2:0]          symbol_kind,
  output logic                tone_on,
  output logic [14:0]         frequency_hz,
  output logic [15:0]         duration_ms,
  output logic                last_of_run
);

  mck_pkg::char_info_t info;
  logic [5:0]  pat;
  logic [2:0]  count;
  logic [2:0]  kind_next;
  logic        tone_next;
  logic [14:0] freq_next;
  logic [15:0] dur_next;

  assign info              = mck_pkg::char_lookup(char_code);
  assign status.char_class = info.char_class;
  assign status.more       = (count > 3'd1);

  always_comb begin
    kind_next = mck_pkg::KIND_LGAP;
    tone_next = 1'b0;
    freq_next = '0;
    dur_next  = cfg.letter_gap;
    unique case (ctrl.emit_sel)
      mck_pkg::EMIT_ELEM: begin
        kind_next = pat[5] ? mck_pkg::KIND_DASH : mck_pkg::KIND_DOT;
        tone_next = 1'b1;
        freq_next = cfg.tone_frequency;
        dur_next  = pat[5] ? cfg.dash_duration : cfg.dot_duration;
      end
      mck_pkg::EMIT_EGAP: begin
        kind_next = mck_pkg::KIND_EGAP;
        dur_next  = cfg.element_gap;
      end
      mck_pkg::EMIT_WGAP: begin
        kind_next = mck_pkg::KIND_WGAP;
        dur_next  = cfg.word_gap;
      end
      mck_pkg::EMIT_BUZZ: begin
        kind_next = mck_pkg::KIND_BUZZ;
        tone_next = 1'b1;
        freq_next = mck_pkg::BUZZ_FREQ;
        dur_next  = mck_pkg::BUZZ_MS;
      end
      default: begin
        kind_next = mck_pkg::KIND_LGAP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.load && accept) begin
      pat   <= info.pat;
      count <= info.len;
    end else if (ctrl.shift) begin
      pat   <= {pat[4:0], 1'b0};
      count <= count - 3'd1;
    end
    symbol_kind  <= kind_next;
    tone_on      <= tone_next;
    frequency_hz <= freq_next;
    duration_ms  <= dur_next;
    last_of_run  <= ctrl.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (ctrl.emit_sel != mck_pkg::EMIT_NONE);
    end
  end

endmodule

// ===== sim/morse_character_keyer_test.sv =====
// Self-checking testbench for morse_character_keyer: a queued request driver,
// a symbol monitor and an in-bench predictor of the keyed symbol runs.
// Depends on mck_pkg (symbol kinds, register indexes, reset values) and the RTL.
module morse_character_keyer_test;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [2:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [2:0] SPARE_INDEX_HI = 3'd7;

  // Cycles of quiet required before a register write. Every request yields
  // at least one symbol, so once all are in the keyer is idle; this is margin.
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int IDLE_PERCENT  = 27;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [7:0]  char_code = 8'h00;
  logic        busy;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'h0000;
  logic        result_strobe;
  logic [2:0]  symbol_kind;
  logic        tone_on;
  logic [14:0] frequency_hz;
  logic [15:0] duration_ms;
  logic        last_of_run;

  morse_character_keyer u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .char_code     (char_code),
    .busy          (busy),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .symbol_kind   (symbol_kind),
    .tone_on       (tone_on),
    .frequency_hz  (frequency_hz),
    .duration_ms   (duration_ms),
    .last_of_run   (last_of_run)
  );

  // One pending request is either a character to key or a register write.
  typedef struct {
    logic        is_write;
    logic [7:0]  ch;
    logic [2:0]  idx;
    logic [15:0] val;
  } keyer_request_t;

  // One symbol the keyer should emit. The tag is the cycle at which the
  // request that caused it was taken, so that a symbol can never be matched
  // against a request taken at the same clock edge.
  typedef struct {
    logic [2:0]  kind;
    logic        tone;
    logic [14:0] freq;
    logic [15:0] dur;
    logic        last;
    int          tag;
  } symbol_t;

  keyer_request_t pending_requests[$];
  symbol_t        expected_symbols[$];

  // The bench's own copy of the keyer's settings.
  logic [14:0] tone_freq_set  = mck_pkg::RST_TONE_FREQUENCY;
  logic [15:0] dot_len_set    = mck_pkg::RST_DOT_DURATION;
  logic [15:0] dash_len_set   = mck_pkg::RST_DASH_DURATION;
  logic [15:0] elem_gap_set   = mck_pkg::RST_ELEMENT_GAP;
  logic [15:0] letter_gap_set = mck_pkg::RST_LETTER_GAP;
  logic [15:0] word_gap_set   = mck_pkg::RST_WORD_GAP;

  int cyc = 0;
  int fail_count = 0;
  int taken = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // Dots and dashes of a folded character, first element first. An empty
  // string means the character has no Morse code.
  function automatic string morse_marks(input logic [7:0] c);
    case (c)
      "a": return ".-";
      "b": return "-...";
      "c": return "-.-.";
      "d": return "-..";
      "e": return ".";
      "f": return "..-.";
      "g": return "--.";
      "h": return "....";
      "i": return "..";
      "j": return ".---";
      "k": return "-.-";
      "l": return ".-..";
      "m": return "--";
      "n": return "-.";
      "o": return "---";
      "p": return ".--.";
      "q": return "--.-";
      "r": return ".-.";
      "s": return "...";
      "t": return "-";
      "u": return "..-";
      "v": return "...-";
      "w": return ".--";
      "x": return "-..-";
      "y": return "-.--";
      "z": return "--..";
      "0": return "-----";
      "1": return ".----";
      "2": return "..---";
      "3": return "...--";
      "4": return "....-";
      "5": return ".....";
      "6": return "-....";
      "7": return "--...";
      "8": return "---..";
      "9": return "----.";
      ".": return ".-.-.-";
      ",": return "--..--";
      default: return "";
    endcase
  endfunction

  task automatic add_symbol(input logic [2:0] kind, input logic tone,
                            input logic [14:0] freq, input logic [15:0] dur,
                            input logic last, input int tag);
    symbol_t s;
    s.kind = kind;
    s.tone = tone;
    s.freq = freq;
    s.dur  = dur;
    s.last = last;
    s.tag  = tag;
    expected_symbols.insert(expected_symbols.size(), s);
  endtask

  // Works out the whole symbol run for one taken character.
  task automatic queue_expected_run(input logic [7:0] raw, input int tag);
    logic [7:0] c;
    string      marks;
    int         i;
    c = raw;
    // Only plain upper-case letters fold; bytes with bit 7 set stay invalid.
    if (c >= "A" && c <= "Z") begin
      c = c + 8'd32;
    end
    if (c == " ") begin
      add_symbol(mck_pkg::KIND_WGAP, 1'b0, 15'd0, word_gap_set, 1'b1, tag);
    end else begin
      marks = morse_marks(c);
      if (marks.len() == 0) begin
        add_symbol(mck_pkg::KIND_BUZZ, 1'b1, 15'd200, 16'd1000, 1'b1, tag);
      end else begin
        for (i = 0; i < marks.len(); i++) begin
          if (marks[i] == "-") begin
            add_symbol(mck_pkg::KIND_DASH, 1'b1, tone_freq_set, dash_len_set, 1'b0,
                       tag);
          end else begin
            add_symbol(mck_pkg::KIND_DOT, 1'b1, tone_freq_set, dot_len_set, 1'b0,
                       tag);
          end
          if (i + 1 < marks.len()) begin
            add_symbol(mck_pkg::KIND_EGAP, 1'b0, 15'd0, elem_gap_set, 1'b0, tag);
          end
        end
        add_symbol(mck_pkg::KIND_LGAP, 1'b0, 15'd0, letter_gap_set, 1'b1, tag);
      end
    end
  endtask

  // Mirrors a register write; the tone frequency keeps its low 15 bits and
  // spare indexes are dropped.
  task automatic apply_write(input logic [2:0] idx, input logic [15:0] val);
    case (idx)
      mck_pkg::REG_TONE_FREQUENCY: tone_freq_set  = val[14:0];
      mck_pkg::REG_DOT_DURATION:   dot_len_set    = val;
      mck_pkg::REG_DASH_DURATION:  dash_len_set   = val;
      mck_pkg::REG_ELEMENT_GAP:    elem_gap_set   = val;
      mck_pkg::REG_LETTER_GAP:     letter_gap_set = val;
      mck_pkg::REG_WORD_GAP:       word_gap_set   = val;
      default: ;
    endcase
  endtask

  // Request driver. A character request is held on start until the keyer
  // takes it (start high with busy low); a register write is only issued
  // once the keyer is quiet and every expected symbol has come back. Between
  // requests start idles at random, except in one stretch of the run where
  // requests are offered back to back so that each starts as busy falls.
  always @(posedge clk) begin : request_driver
    logic next_start;
    logic next_we;
    logic steady;
    if (rst) begin
      start <= 1'b0;
      cfg_we <= 1'b0;
      quiet_cycles = 0;
    end else begin
      next_start = start;
      next_we = 1'b0;
      if (start && !busy) begin
        queue_expected_run(char_code, cyc);
        taken = taken + 1;
        next_start = 1'b0;
      end
      if (busy || start || result_strobe || expected_symbols.size() != 0) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      steady = (taken >= 100 && taken < 170);
      if (!next_start && pending_requests.size() != 0) begin
        if (pending_requests[0].is_write) begin
          if (quiet_cycles >= SETTLE_CYCLES) begin
            next_we = 1'b1;
            cfg_index <= pending_requests[0].idx;
            cfg_data <= pending_requests[0].val;
            apply_write(pending_requests[0].idx, pending_requests[0].val);
            void'(pending_requests.pop_front());
          end
        end else if (steady || $urandom_range(0, 99) >= IDLE_PERCENT) begin
          next_start = 1'b1;
          char_code <= pending_requests[0].ch;
          void'(pending_requests.pop_front());
        end
      end
      start <= next_start;
      cfg_we <= next_we;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Symbol monitor. The keyer cannot be stalled, so every strobe is taken
  // and compared with the oldest expected symbol.
  always @(posedge clk) begin : symbol_monitor
    symbol_t want;
    if (!rst && result_strobe) begin
      if (expected_symbols.size() == 0 || expected_symbols[0].tag >= cyc) begin
        $error("result_strobe: expected no symbol, got kind %0d", symbol_kind);
        fail_count++;
      end else begin
        want = expected_symbols.pop_front();
        check_field("symbol_kind", want.kind, symbol_kind);
        check_field("tone_on", want.tone, tone_on);
        check_field("frequency_hz", want.freq, frequency_hz);
        check_field("duration_ms", want.dur, duration_ms);
        check_field("last_of_run", want.last, last_of_run);
      end
    end
  end

  task automatic add_char(input logic [7:0] c);
    keyer_request_t r;
    r.is_write = 1'b0;
    r.ch  = c;
    r.idx = 3'd0;
    r.val = 16'h0000;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic add_write(input logic [2:0] idx, input logic [15:0] val);
    keyer_request_t r;
    r.is_write = 1'b1;
    r.ch  = 8'h00;
    r.idx = idx;
    r.val = val;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  task automatic add_all_writes(input logic [15:0] val);
    add_write(mck_pkg::REG_TONE_FREQUENCY, val);
    add_write(mck_pkg::REG_DOT_DURATION, val);
    add_write(mck_pkg::REG_DASH_DURATION, val);
    add_write(mck_pkg::REG_ELEMENT_GAP, val);
    add_write(mck_pkg::REG_LETTER_GAP, val);
    add_write(mck_pkg::REG_WORD_GAP, val);
  endtask

  // Register values lean toward the extremes and short lengths.
  function automatic logic [15:0] pick_reg_value();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 20));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly characters with a Morse code in either case, with spaces and
  // arbitrary bytes mixed in.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    end else if (r < 60) begin
      return 8'h30 + 8'($urandom_range(0, 9));
    end else if (r < 66) begin
      return $urandom_range(0, 1) ? 8'h2E : 8'h2C;
    end else if (r < 76) begin
      return 8'h20;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin : stimulus
    int p;
    int k;

    // Directed requests under the reset settings: both ends of each letter
    // range in both cases, digits, period and comma (the six-element codes),
    // one-element letters, a space, and invalid bytes including the
    // neighbors of the folded range and bytes with the top bit set.
    add_char("A");
    add_char("Z");
    add_char("a");
    add_char("z");
    add_char("0");
    add_char("9");
    add_char(".");
    add_char(",");
    add_char("E");
    add_char("T");
    add_char(" ");
    add_char(8'h00);
    add_char(8'hFF);
    add_char(8'h80);
    add_char(8'h7F);
    add_char(8'h40);
    add_char(8'h5B);
    add_char(8'h60);
    add_char(8'h7B);
    add_char(8'h2F);
    add_char(8'h3A);
    add_char(8'h2D);
    add_char("q");

    // All ones: the frequency loses bit 15, every length is at its maximum.
    add_all_writes(16'hFFFF);
    add_write(SPARE_INDEX_HI, 16'h0000);
    add_char(".");
    add_char(" ");
    add_char(8'hC1);

    // All zeros: zero lengths and a zero frequency pass straight through.
    add_all_writes(16'h0000);
    add_write(SPARE_INDEX_LO, 16'hFFFF);
    add_char(",");
    add_char(" ");
    add_char("k");

    // Random settings, each followed by a batch of random characters.
    for (p = 0; p < 6; p++) begin
      add_write(mck_pkg::REG_TONE_FREQUENCY, pick_reg_value());
      add_write(mck_pkg::REG_DOT_DURATION, pick_reg_value());
      add_write(mck_pkg::REG_DASH_DURATION, pick_reg_value());
      add_write(mck_pkg::REG_ELEMENT_GAP, pick_reg_value());
      add_write(mck_pkg::REG_LETTER_GAP, pick_reg_value());
      add_write(mck_pkg::REG_WORD_GAP, pick_reg_value());
      if ($urandom_range(0, 1)) begin
        add_write($urandom_range(0, 1) ? SPARE_INDEX_LO : SPARE_INDEX_HI,
                  16'($urandom));
      end
      for (k = 0; k < 42; k++) begin
        add_char(pick_char());
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Drain: every request taken and every expected symbol seen, then a
    // short tail to catch stray strobes.
    while (pending_requests.size() != 0 || start || expected_symbols.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS morse_character_keyer");
    end else begin
      $display("FAIL morse_character_keyer");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL morse_character_keyer");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/mck_pkg.sv
src/mck_sequencer.sv
src/mck_datapath.sv
src/morse_character_keyer.sv
sim/morse_character_keyer_test.sv
